// ----- design/efp_pkg.sv -----
// Shared constants for the escape-time fractal pixel block.
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

    localparam int unsigned INT_BITS           = 8;
    localparam int unsigned MAX_IMAGE_SIZE_DEF = 4096;
    localparam int unsigned FRAC_BITS_DEF      = 28;

    localparam int unsigned PIX_W      = 12;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned ITER_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd1;

    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 13'd256;
    localparam logic [ITER_W-1:0] MAX_ITER_RST   = 16'd1000;

endpackage

`default_nettype wire

// ----- design/escape_time_fractal_pixel.sv -----
// Escape-time fractal pixel: maps a pixel to a point and counts escape iterations.
//
// The input channel takes one pixel (pixel_row, pixel_column) per beat with
// in_valid and in_stall; the block holds in_stall high from the beat it accepts
// until the result beat has been taken. The output channel presents
// iteration_count with out_valid and waits while out_stall is high, holding
// the count. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready and writes image_size (index 0) or
// max_iterations (index 1); other indexes are ignored.
// A serial restoring divider produces one quotient bit per cycle and maps the
// column and then the row. Each escape iteration then steps through ST_CHECK,
// ST_ADD and ST_MAG for the adds and magnitudes, then ST_SQ, in which one
// half-width multiplier forms the three partial products of each of the three
// squares, and ST_DRAIN to drain the accumulator.
// Reset returns the block to idle, drops out_valid and loads image_size 256
// and max_iterations 1000.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_pixel
    import efp_pkg::*;
#(
    parameter int unsigned MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
    parameter int unsigned FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      pixel_row,
    input  wire logic [PIX_W-1:0]      pixel_column,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [ITER_W-1:0]          iteration_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned FX_W      = INT_BITS + FRAC_BITS;
    localparam int unsigned HALF_W    = (FX_W + 1) / 2;
    localparam int unsigned PROD_W    = 2 * HALF_W;
    localparam int unsigned SQ_W      = 2 * FX_W;
    localparam int unsigned SZ_W      = $clog2(MAX_IMAGE_SIZE + 1);
    localparam int unsigned IDX5_W    = PIX_W + 3;
    localparam int unsigned NUM_W     = IDX5_W + FRAC_BITS - 1;
    localparam int unsigned CMP_W     = NUM_W + 2;
    localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
    localparam logic [FX_W:0]   FX_FOUR =
        {{(FX_W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};
    localparam logic [CMP_W-1:0] OFF_CX =
        {{(CMP_W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
    localparam logic [CMP_W-1:0] OFF_CY =
        {{(CMP_W-FRAC_BITS-1){1'b0}}, 1'b1, 2'b01, {(FRAC_BITS-2){1'b0}}};
    localparam logic [CMP_W-1:0] FX_MAX_C = CMP_W'(FX_MAX);
    localparam logic [CMP_W-1:0] LIM_CX   = FX_MAX_C + OFF_CX;
    localparam logic [CMP_W-1:0] LIM_CY   = FX_MAX_C + OFF_CY;

    localparam logic [1:0] OP_X     = 2'd0;
    localparam logic [1:0] OP_Y     = 2'd1;
    localparam logic [1:0] OP_S     = 2'd2;
    localparam logic [1:0] PART_LO  = 2'd0;
    localparam logic [1:0] PART_MID = 2'd1;
    localparam logic [1:0] PART_HI  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_ADD,
        ST_MAG,
        ST_SQ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic logic [FX_W-1:0] sat1(input logic [FX_W:0] v);
        if (v[FX_W] != v[FX_W-1])
            return v[FX_W] ? FX_MIN : FX_MAX;
        return v[FX_W-1:0];
    endfunction

    function automatic logic [FX_W-1:0] sat2(input logic [FX_W+1:0] v);
        if (v[FX_W+1:FX_W-1] == 3'b000 || v[FX_W+1:FX_W-1] == 3'b111)
            return v[FX_W-1:0];
        return v[FX_W+1] ? FX_MIN : FX_MAX;
    endfunction

    function automatic logic [FX_W:0] ext1(input logic [FX_W-1:0] v);
        return {v[FX_W-1], v};
    endfunction

    function automatic logic [FX_W+1:0] ext2(input logic [FX_W-1:0] v);
        return {{2{v[FX_W-1]}}, v};
    endfunction

    function automatic logic [FX_W-1:0] magnitude(input logic [FX_W-1:0] v);
        return v[FX_W-1] ? (~v + {{(FX_W-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic logic [NUM_W-1:0] numerator(input logic [PIX_W-1:0] idx);
        logic [IDX5_W-1:0] idx5;
        idx5 = IDX5_W'({idx, 2'b00}) + IDX5_W'(idx);
        return {idx5, {(FRAC_BITS-1){1'b0}}};
    endfunction

    state_t                 state_reg, state_next;
    logic [SIZE_W-1:0]      image_size_reg;
    logic [ITER_W-1:0]      max_iter_reg;
    logic [ITER_W-1:0]      n_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   div_row_reg;
    logic [1:0]             op_reg, part_reg;
    logic                   acc_vld_reg;
    logic [1:0]             acc_op_reg, acc_part_reg;

    logic [SZ_W-1:0]        size_reg;
    logic [PIX_W-1:0]       row_reg;
    logic [SZ_W-1:0]        div_rem_reg;
    logic [NUM_W-1:0]       div_num_reg;
    logic [FX_W-1:0]        cx_reg, cy_reg;
    logic [FX_W-1:0]        x2_reg, y2_reg, w_reg;
    logic [FX_W-1:0]        d_reg, e_reg, x_reg, y_reg;
    logic [FX_W-1:0]        mag_x_reg, mag_y_reg, mag_s_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SQ_W-1:0]        acc_reg;

    logic                   in_accept;
    logic                   go;
    logic [FX_W:0]          esc_sum;
    logic [SZ_W-1:0]        eff_size;
    logic [SZ_W:0]          div_trial, div_diff;
    logic                   div_ge;
    logic                   div_end;
    logic [CMP_W-1:0]       q_ext, map_lim, map_off;
    logic [FX_W-1:0]        coord;
    logic [FX_W-1:0]        mag_sel;
    logic [HALF_W-1:0]      mul_a, mul_b, m_lo, m_hi;
    logic [SQ_W-1:0]        acc_shift, acc_sum;
    logic [SQ_W-FRAC_BITS-1:0] sq_top;
    logic [FX_W-1:0]        sq_res;

    assign in_stall        = (state_reg != ST_IDLE);
    assign in_accept       = in_valid && !in_stall;
    assign out_valid       = (state_reg == ST_DONE);
    assign iteration_count = n_reg;
    assign cfg_ready       = 1'b1;

    always_comb
    begin
        if (image_size_reg == '0)
            eff_size = SZ_W'(1);
        else if (32'(image_size_reg) > 32'(MAX_IMAGE_SIZE))
            eff_size = SZ_W'(MAX_IMAGE_SIZE);
        else
            eff_size = SZ_W'(image_size_reg);
    end

    assign esc_sum = {1'b0, x2_reg} + {1'b0, y2_reg};
    assign go      = (esc_sum <= FX_FOUR) && (n_reg < max_iter_reg);

    assign div_end   = (div_cnt_reg == DIV_CNT_W'(NUM_W));
    assign div_trial = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign div_diff  = div_trial - {1'b0, size_reg};
    assign div_ge    = !div_diff[SZ_W];

    assign q_ext   = CMP_W'(div_num_reg);
    assign map_lim = div_row_reg ? LIM_CY : LIM_CX;
    assign map_off = div_row_reg ? OFF_CY : OFF_CX;
    always_comb
    begin
        if (q_ext > map_lim)
            coord = FX_MAX;
        else
            coord = FX_W'(q_ext - map_off);
    end

    always_comb
    begin
        case (op_reg)
            OP_X:    mag_sel = mag_x_reg;
            OP_Y:    mag_sel = mag_y_reg;
            default: mag_sel = mag_s_reg;
        endcase
        m_lo = mag_sel[HALF_W-1:0];
        m_hi = HALF_W'(mag_sel[FX_W-1:HALF_W]);
        case (part_reg)
            PART_LO:  begin mul_a = m_lo; mul_b = m_lo; end
            PART_MID: begin mul_a = m_hi; mul_b = m_lo; end
            default:  begin mul_a = m_hi; mul_b = m_hi; end
        endcase
    end

    always_comb
    begin
        case (acc_part_reg)
            PART_LO:  acc_shift = SQ_W'(prod_reg);
            PART_MID: acc_shift = SQ_W'(prod_reg) << (HALF_W + 1);
            PART_HI:  acc_shift = SQ_W'(prod_reg) << (2 * HALF_W);
            default:  acc_shift = '0;
        endcase
        acc_sum = ((acc_part_reg == PART_LO) ? '0 : acc_reg) + acc_shift;
        sq_top  = acc_sum[SQ_W-1:FRAC_BITS];
        sq_res  = (sq_top > (SQ_W-FRAC_BITS)'(FX_MAX)) ? FX_MAX : sq_top[FX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DIV;
            ST_DIV:   if (div_end && div_row_reg) state_next = ST_CHECK;
            ST_CHECK: state_next = go ? ST_ADD : ST_DONE;
            ST_ADD:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_SQ;
            ST_SQ:    if (op_reg == OP_S && part_reg == PART_HI) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_CHECK;
            ST_DONE:  if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            image_size_reg <= IMAGE_SIZE_RST;
            max_iter_reg   <= MAX_ITER_RST;
            n_reg          <= '0;
            div_cnt_reg    <= '0;
            div_row_reg    <= 1'b0;
            op_reg         <= OP_X;
            part_reg       <= PART_LO;
            acc_vld_reg    <= 1'b0;
            acc_op_reg     <= OP_X;
            acc_part_reg   <= PART_LO;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_SIZE)
                    image_size_reg <= cfg_data[SIZE_W-1:0];
                else if (cfg_index == REG_MAX_ITER)
                    max_iter_reg <= cfg_data[ITER_W-1:0];
            end
            acc_vld_reg  <= (state_reg == ST_SQ);
            acc_op_reg   <= op_reg;
            acc_part_reg <= part_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    div_cnt_reg <= '0;
                    div_row_reg <= 1'b0;
                end
                ST_DIV:
                begin
                    if (div_end)
                    begin
                        div_cnt_reg <= '0;
                        div_row_reg <= 1'b1;
                        n_reg       <= '0;
                    end
                    else
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
                ST_ADD:
                    n_reg <= n_reg + ITER_W'(1);
                ST_MAG:
                begin
                    op_reg   <= OP_X;
                    part_reg <= PART_LO;
                end
                ST_SQ:
                begin
                    if (part_reg == PART_HI)
                    begin
                        part_reg <= PART_LO;
                        op_reg   <= op_reg + 2'd1;
                    end
                    else
                        part_reg <= part_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            size_reg    <= eff_size;
            row_reg     <= pixel_row;
            div_num_reg <= numerator(pixel_column);
            div_rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (!div_end)
            begin
                div_rem_reg <= div_ge ? div_diff[SZ_W-1:0] : div_trial[SZ_W-1:0];
                div_num_reg <= {div_num_reg[NUM_W-2:0], div_ge};
            end
            else if (!div_row_reg)
            begin
                cx_reg      <= coord;
                div_num_reg <= numerator(row_reg);
                div_rem_reg <= '0;
            end
            else
            begin
                cy_reg <= coord;
                x2_reg <= '0;
                y2_reg <= '0;
                w_reg  <= '0;
            end
        end
        if (state_reg == ST_CHECK)
        begin
            d_reg <= x2_reg - y2_reg;
            e_reg <= sat2(ext2(w_reg) - ext2(x2_reg) - ext2(y2_reg));
        end
        if (state_reg == ST_ADD)
        begin
            x_reg <= sat1(ext1(d_reg) + ext1(cx_reg));
            y_reg <= sat1(ext1(e_reg) + ext1(cy_reg));
        end
        if (state_reg == ST_MAG)
        begin
            mag_x_reg <= magnitude(x_reg);
            mag_y_reg <= magnitude(y_reg);
            mag_s_reg <= magnitude(sat1(ext1(x_reg) + ext1(y_reg)));
        end
        if (state_reg == ST_SQ)
            prod_reg <= mul_a * mul_b;
        if (acc_vld_reg)
        begin
            acc_reg <= acc_sum;
            if (acc_part_reg == PART_HI)
            begin
                case (acc_op_reg)
                    OP_X:    x2_reg <= sq_res;
                    OP_Y:    y2_reg <= sq_res;
                    default: w_reg  <= sq_res;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
